### design/mf3_pkg.sv
// ----------------------------------------------------------------------------
// 3x3 median filter package
// Shared constants, types and compare helpers of the median filter blocks.
// ----------------------------------------------------------------------------
package mf3_pkg;

   localparam int PIX_W          = 8;
   localparam int CFG_W          = 11;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int RESET_SIZE     = 1024;
   localparam int MIN_WIDTH      = 2;
   localparam int MIN_HEIGHT     = 1;
   localparam int FIFO_DEPTH     = 16;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef logic [PIX_W-1:0] pix_type;

   // Window entry index is column * 3 + row, column 2 being the newest.
   typedef pix_type [8:0] win_type;

   // One accepted item on its way into the line stores.
   typedef struct packed {
      logic    col0;
      logic    last_col;
      logic    r_ge1;
      logic    r_ge2;
      logic    flush;
      pix_type val;
   } item_type;

   // Control that travels alongside a window through the median pipeline.
   typedef struct packed {
      logic valid;
      logic emit_a;
      logic emit_b;
      logic last;
   } ctl_type;

   typedef struct packed {
      pix_type lo;
      pix_type md;
      pix_type hi;
   } trio_type;

   typedef struct packed {
      logic    last;
      pix_type median;
   } rsp_type;

   function automatic pix_type min2(pix_type a, pix_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic pix_type max2(pix_type a, pix_type b);
      return (a < b) ? b : a;
   endfunction

   function automatic pix_type min3(pix_type a, pix_type b, pix_type c);
      return min2(min2(a, b), c);
   endfunction

   function automatic pix_type max3(pix_type a, pix_type b, pix_type c);
      return max2(max2(a, b), c);
   endfunction

   function automatic pix_type med3(pix_type a, pix_type b, pix_type c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic trio_type sort3(pix_type a, pix_type b, pix_type c);
      trio_type t;
      t.lo = min3(a, b, c);
      t.md = med3(a, b, c);
      t.hi = max3(a, b, c);
      return t;
   endfunction

endpackage

### design/mf3_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/mf3_window.sv
// ----------------------------------------------------------------------------
// 3x3 median filter line stores and window
// Two line stores feed the newest window column; the window shifts per item.
// ----------------------------------------------------------------------------
module mf3_window #(
   parameter int MAX_WIDTH = mf3_pkg::DEF_MAX_WIDTH,
   localparam int AW       = $clog2(MAX_WIDTH)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  mf3_pkg::item_type  in_item,
   input  logic [AW-1:0]      in_addr,
   output logic               clearing,
   output mf3_pkg::ctl_type   out_ctl,
   output mf3_pkg::win_type   out_win
);

   logic              s1_valid_ff;
   mf3_pkg::item_type s1_item_ff;
   logic [AW-1:0]     s1_addr_ff;
   logic              clr_busy_ff;
   logic [AW-1:0]     clr_addr_ff;
   mf3_pkg::pix_type  above_rd;
   mf3_pkg::pix_type  two_rd;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   mf3_pkg::pix_type  above_wdata;
   mf3_pkg::pix_type  two_wdata;
   mf3_pkg::pix_type  top_px;
   mf3_pkg::pix_type  mid_px;
   mf3_pkg::win_type  window_ff;
   mf3_pkg::win_type  window_in;
   mf3_pkg::ctl_type  ctl_ff;
   mf3_pkg::ctl_type  ctl_in;

   // The stores are written either by the clearing sweep or by the item in
   // the first stage; both stores share the address.
   assign wr_en       = clr_busy_ff | s1_valid_ff;
   assign wr_addr     = clr_busy_ff ? clr_addr_ff : s1_addr_ff;
   assign above_wdata = clr_busy_ff ? '0 : s1_item_ff.val;
   assign two_wdata   = clr_busy_ff ? '0 : above_rd;

   mf3_ram #(
      .WIDTH (mf3_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (above_wdata),
      .rd_addr (in_addr),
      .rd_data (above_rd)
   );

   mf3_ram #(
      .WIDTH (mf3_pkg::PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_two_above (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (two_wdata),
      .rd_addr (in_addr),
      .rd_data (two_rd)
   );

   // Rows above the top of the frame are padding.
   assign top_px = s1_item_ff.r_ge2 ? two_rd : '0;
   assign mid_px = s1_item_ff.r_ge1 ? above_rd : '0;

   always_comb begin
      window_in = window_ff;
      for (int i = 0; i < 6; i++) begin
         window_in[i] = s1_item_ff.col0 ? '0 : window_ff[i + 3];
      end
      window_in[6] = top_px;
      window_in[7] = mid_px;
      window_in[8] = s1_item_ff.val;
   end

   always_comb begin
      ctl_in.valid  = s1_valid_ff;
      ctl_in.emit_a = s1_item_ff.r_ge1 & ~s1_item_ff.col0;
      ctl_in.emit_b = s1_item_ff.r_ge1 & s1_item_ff.last_col;
      ctl_in.last   = s1_item_ff.flush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
         ctl_ff      <= '0;
      end else begin
         s1_valid_ff <= in_valid;
         ctl_ff      <= ctl_in;
         if (clr_busy_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= in_item;
      s1_addr_ff <= in_addr;
      if (s1_valid_ff) begin
         window_ff <= window_in;
      end
   end

   assign clearing = clr_busy_ff;
   assign out_ctl  = ctl_ff;
   assign out_win  = window_ff;

endmodule

### design/mf3_median.sv
// ----------------------------------------------------------------------------
// 3x3 median filter median pipeline
// Column sort, row merge and final pick over three register stages.
// ----------------------------------------------------------------------------
module mf3_median (
   input  logic              clock,
   input  logic              reset,
   input  mf3_pkg::ctl_type  in_ctl,
   input  mf3_pkg::win_type  in_win,
   output mf3_pkg::ctl_type  out_ctl,
   output mf3_pkg::pix_type  out_med_a,
   output mf3_pkg::pix_type  out_med_b
);

   mf3_pkg::ctl_type        m1_ctl_ff;
   mf3_pkg::trio_type [2:0] col_in;
   mf3_pkg::trio_type [2:0] col_ff;
   mf3_pkg::ctl_type        m2_ctl_ff;
   mf3_pkg::pix_type        a_lo_ff, a_md_ff, a_hi_ff;
   mf3_pkg::pix_type        b_lo_ff, b_md_ff;
   mf3_pkg::ctl_type        m3_ctl_ff;
   mf3_pkg::pix_type        med_a_ff, med_b_ff;

   // Each window column sorted on its own.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         col_in[k] = mf3_pkg::sort3(in_win[3 * k], in_win[3 * k + 1], in_win[3 * k + 2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ctl_ff <= '0;
         m2_ctl_ff <= '0;
         m3_ctl_ff <= '0;
      end else begin
         m1_ctl_ff <= in_ctl;
         m2_ctl_ff <= m1_ctl_ff;
         m3_ctl_ff <= m2_ctl_ff;
      end
   end

   // The second result sees columns one and two beside a zero column, so its
   // low is the larger low, its middle the smaller middle and its high zero.
   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      a_lo_ff  <= mf3_pkg::max3(col_ff[0].lo, col_ff[1].lo, col_ff[2].lo);
      a_md_ff  <= mf3_pkg::med3(col_ff[0].md, col_ff[1].md, col_ff[2].md);
      a_hi_ff  <= mf3_pkg::min3(col_ff[0].hi, col_ff[1].hi, col_ff[2].hi);
      b_lo_ff  <= mf3_pkg::max2(col_ff[1].lo, col_ff[2].lo);
      b_md_ff  <= mf3_pkg::min2(col_ff[1].md, col_ff[2].md);
      med_a_ff <= mf3_pkg::med3(a_lo_ff, a_md_ff, a_hi_ff);
      med_b_ff <= mf3_pkg::min2(b_lo_ff, b_md_ff);
   end

   assign out_ctl   = m3_ctl_ff;
   assign out_med_a = med_a_ff;
   assign out_med_b = med_b_ff;

endmodule

### design/mf3_fifo.sv
// ----------------------------------------------------------------------------
// 3x3 median filter result queue
// Register queue taking up to two entries per cycle and giving one.
// ----------------------------------------------------------------------------
module mf3_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = mf3_pkg::FIFO_DEPTH,
   localparam int PW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_a,
   input  logic [WIDTH-1:0] data_a,
   input  logic             push_b,
   input  logic [WIDTH-1:0] data_b,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data,
   output logic [CW-1:0]    count
);

   // DEPTH is a power of two so that the pointers wrap on their own.
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             pop;

   assign pop = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PW'(push_a) + PW'(push_b);
         rd_ptr_ff <= rd_ptr_ff + PW'(pop);
         count_ff  <= count_ff + CW'(push_a) + CW'(push_b) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         mem_ff[wr_ptr_ff + PW'(push_a)] <= data_b;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### design/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// 3x3 median filter unit
// An item passes the window registers, the median stages and the result queue.
// Throughput: one item per clock while req_tready is high; the last column
// of a row gives two results; the queue sends one per clock if rsp_tready is high.
// Reset: synchronous; afterwards both line stores are zeroed over all MAX_WIDTH
// addresses, during which req_tready is low (configuration writes still taken).
// ----------------------------------------------------------------------------
//
// Pixels arrive in raster order. The row and column counters here give each
// item its position, the window block keeps the two rows above in line stores
// and shifts a 3x3 window, the median block picks the median of nine in three
// register stages, and a small queue parts the result side from the pipeline.
// The window centred one row up and one column left completes with each item
// past the first row and column, and the last column of a row also completes
// the window on its right edge against a zero column. A row of flush items after
// the frame stands for the zero row below; its last result carries rsp_tlast.
//
// Input items are taken only while the queue has room for every result that
// the items already in flight may still give, so the pipeline itself never
// stalls and a stalled result side only stops new items.
module median_filter_3x3_unit #(
   parameter int MAX_WIDTH  = mf3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mf3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Input channel.
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mf3_pkg::PIX_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                      req_tuser,   // [0] operation (1 = pixel taken as zero)
   // Result channel.
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [mf3_pkg::PIX_W-1:0] rsp_tdata,   // [7:0] median
   output logic                      rsp_tlast,   // last_of_frame
   // Configuration write channel.
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_index,
   input  logic [mf3_pkg::CFG_W-1:0] csr_data
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int CMP_A = (mf3_pkg::CFG_W > CW + 1) ? mf3_pkg::CFG_W : CW + 1;
   localparam int CMP_W = (CMP_A > RW + 1) ? CMP_A : RW + 1;
   localparam int RST_W = (mf3_pkg::RESET_SIZE < MAX_WIDTH) ? mf3_pkg::RESET_SIZE : MAX_WIDTH;
   localparam int RST_H = (mf3_pkg::RESET_SIZE < MAX_HEIGHT) ? mf3_pkg::RESET_SIZE
                                                              : MAX_HEIGHT;
   localparam int FCW   = $clog2(mf3_pkg::FIFO_DEPTH + 1);
   localparam int IFW   = FCW;
   localparam int SUM_W = FCW + 2;

   // Configuration, kept already clamped to the legal range.
   logic [CW-1:0]     width_last_ff, width_last_in;
   logic [RW-1:0]     height_ff, height_in;
   logic [CMP_W-1:0]  cfg_ext;
   logic [CMP_W-1:0]  w_eff;
   logic [CMP_W-1:0]  h_eff;

   // Position counters.
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_eff;
   logic              last_col;
   logic              flush_row;
   logic              accept;
   mf3_pkg::item_type item;

   // Flow control.
   logic [IFW-1:0]    inflight_ff, inflight_in;
   logic [FCW-1:0]    fifo_count;
   logic [SUM_W-1:0]  credit;
   logic              clearing;

   mf3_pkg::ctl_type  win_ctl;
   mf3_pkg::win_type  win;
   mf3_pkg::ctl_type  med_ctl;
   mf3_pkg::pix_type  med_a;
   mf3_pkg::pix_type  med_b;
   mf3_pkg::rsp_type  rsp_a;
   mf3_pkg::rsp_type  rsp_b;
   mf3_pkg::rsp_type  rsp_head;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; the clamp is applied
   // on the way in so that an item may follow in the very next cycle.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign cfg_ext   = CMP_W'(csr_data);

   always_comb begin
      if (cfg_ext < CMP_W'(mf3_pkg::MIN_WIDTH)) begin
         w_eff = CMP_W'(mf3_pkg::MIN_WIDTH);
      end else if (cfg_ext > CMP_W'(MAX_WIDTH)) begin
         w_eff = CMP_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg_ext;
      end
      if (cfg_ext < CMP_W'(mf3_pkg::MIN_HEIGHT)) begin
         h_eff = CMP_W'(mf3_pkg::MIN_HEIGHT);
      end else if (cfg_ext > CMP_W'(MAX_HEIGHT)) begin
         h_eff = CMP_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg_ext;
      end
   end

   always_comb begin
      width_last_in = width_last_ff;
      height_in     = height_ff;
      if (csr_valid && csr_ready) begin
         case (mf3_pkg::reg_index_type'(csr_index))
            mf3_pkg::REG_FRAME_WIDTH: begin
               width_last_in = CW'(w_eff - CMP_W'(1));
            end
            mf3_pkg::REG_FRAME_HEIGHT: begin
               height_in = RW'(h_eff);
            end
            default: begin
               width_last_in = width_last_ff;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Position of the incoming item. A column counter left beyond a narrowed
   // row is taken as the last column, and a row counter at or beyond the
   // height marks the flush row.
   // ---------------------------------------------------------------------
   assign last_col  = (col_ff >= width_last_ff);
   assign col_eff   = last_col ? width_last_ff : col_ff;
   assign flush_row = (row_ff >= height_ff);
   assign accept    = req_tvalid & req_tready;

   always_comb begin
      item.col0     = (col_eff == '0);
      item.last_col = last_col;
      item.r_ge1    = (row_ff != '0);
      item.r_ge2    = (row_ff > RW'(1));
      item.flush    = flush_row;
      item.val      = (req_tuser || flush_row) ? '0 : req_tdata;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = flush_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_eff + CW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: every item in flight may still give two results, so an item is
   // taken only when not clearing and the queue has room for them and two more.
   // ---------------------------------------------------------------------
   assign credit      = SUM_W'(fifo_count) + (SUM_W'(inflight_ff) << 1) + SUM_W'(2);
   assign req_tready  = !clearing && (credit <= SUM_W'(mf3_pkg::FIFO_DEPTH));
   assign inflight_in = inflight_ff + IFW'(accept) - IFW'(med_ctl.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff <= CW'(RST_W - 1);
         height_ff     <= RW'(RST_H);
         col_ff        <= '0;
         row_ff        <= '0;
         inflight_ff   <= '0;
      end else begin
         width_last_ff <= width_last_in;
         height_ff     <= height_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         inflight_ff   <= inflight_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath.
   // ---------------------------------------------------------------------
   mf3_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_item  (item),
      .in_addr  (col_eff),
      .clearing (clearing),
      .out_ctl  (win_ctl),
      .out_win  (win)
   );

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (win_ctl),
      .in_win    (win),
      .out_ctl   (med_ctl),
      .out_med_a (med_a),
      .out_med_b (med_b)
   );

   // Only the right-edge result of the flush row closes the frame.
   assign rsp_a.last   = 1'b0;
   assign rsp_a.median = med_a;
   assign rsp_b.last   = med_ctl.last;
   assign rsp_b.median = med_b;

   mf3_fifo #(
      .WIDTH ($bits(mf3_pkg::rsp_type)),
      .DEPTH (mf3_pkg::FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (med_ctl.valid & med_ctl.emit_a),
      .data_a    (rsp_a),
      .push_b    (med_ctl.valid & med_ctl.emit_b),
      .data_b    (rsp_b),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_head),
      .count     (fifo_count)
   );

   assign rsp_tdata = rsp_head.median;
   assign rsp_tlast = rsp_head.last;

`ifndef SYNTHESIS
   // No item may enter while the line stores are being zeroed.
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_tready
   ) else $error("item taken during line store clearing");

   // The queue always has room for everything the pipeline may still give.
   a_credit_holds: assert property (
      @(posedge clock) disable iff (reset)
      (SUM_W'(fifo_count) + (SUM_W'(inflight_ff) << 1)) <= SUM_W'(mf3_pkg::FIFO_DEPTH)
   ) else $error("result queue credit exceeded");

   // The last item of the flush row returns both counters to the frame start.
   a_frame_wraps: assert property (
      @(posedge clock) disable iff (reset)
      accept && last_col && flush_row |=> (row_ff == '0) && (col_ff == '0)
   ) else $error("counters did not return to frame start");

   // An accepted item is counted as in flight in the next cycle.
   a_inflight_counts: assert property (
      @(posedge clock) disable iff (reset) accept |=> (inflight_ff != '0)
   ) else $error("in-flight count missed an item");
`endif

endmodule
